// File: rtl/qse_pkg.sv
// Shared command codes, line indexes and control types for the quadrature step emulator.
package qse_pkg;

    typedef enum logic [2:0] {
        CMD_TICK    = 3'd0,
        CMD_QUEUE_X = 3'd1,
        CMD_QUEUE_Y = 3'd2,
        CMD_UP      = 3'd3,
        CMD_DOWN    = 3'd4,
        CMD_LEFT    = 3'd5,
        CMD_RIGHT   = 3'd6,
        CMD_TRIGGER = 3'd7
    } qse_cmd_t;

    localparam int LINE_XA   = 0;
    localparam int LINE_XB   = 1;
    localparam int LINE_YA   = 2;
    localparam int LINE_YB   = 3;
    localparam int LINE_FIRE = 4;
    localparam int LINE_CNT  = 5;

    localparam int DELTA_BITS = 16;

    typedef struct packed {
        logic fire;
        logic tick;
        logic queue;
        logic stop;
    } qse_axis_ctl_t;

    typedef struct packed {
        logic changed;
        logic line_a;
        logic line_b;
        logic running;
    } qse_axis_sts_t;

endpackage

// File: rtl/qse_axis.sv
// One encoder axis: run flag, saturating pending count and quadrature phase.
module qse_axis #(
    parameter int PENDING_BITS = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  qse_pkg::qse_axis_ctl_t               ctl,
    input  logic signed [qse_pkg::DELTA_BITS-1:0] step_delta,
    output qse_pkg::qse_axis_sts_t               sts
);
    import qse_pkg::*;

    localparam int SUM_W = ((PENDING_BITS > DELTA_BITS) ? PENDING_BITS : DELTA_BITS) + 1;
    localparam logic signed [SUM_W-1:0] PMAX =
        {{(SUM_W-PENDING_BITS+1){1'b0}}, {(PENDING_BITS-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] PMIN = ~PMAX;

    logic                           running_reg, running_next;
    logic signed [PENDING_BITS-1:0] pending_reg, pending_next;
    logic [1:0]                     phase_reg, phase_next;

    logic signed [PENDING_BITS-1:0] base;
    logic signed [SUM_W-1:0]        sum;
    logic                           changed;

    always_comb
    begin
        base = running_reg ? pending_reg : '0;
        sum  = SUM_W'(base) + SUM_W'(step_delta);
    end

    always_comb
    begin
        running_next = running_reg;
        pending_next = pending_reg;
        phase_next   = phase_reg;
        changed      = 1'b0;
        if (ctl.fire)
        begin
            if (ctl.queue && (step_delta != '0))
            begin
                running_next = 1'b1;
                if (!running_reg)
                begin
                    phase_next = 2'd0;
                end
                if (sum > PMAX)
                begin
                    pending_next = PMAX[PENDING_BITS-1:0];
                end
                else if (sum < PMIN)
                begin
                    pending_next = PMIN[PENDING_BITS-1:0];
                end
                else
                begin
                    pending_next = sum[PENDING_BITS-1:0];
                end
            end
            if (ctl.tick && running_reg)
            begin
                if (pending_reg > 0)
                begin
                    phase_next   = phase_reg + 2'd1;
                    pending_next = pending_reg - 1'b1;
                    changed      = 1'b1;
                end
                else if (pending_reg < 0)
                begin
                    phase_next   = phase_reg - 2'd1;
                    pending_next = pending_reg + 1'b1;
                    changed      = 1'b1;
                end
            end
            if (ctl.stop)
            begin
                running_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg <= 1'b0;
            pending_reg <= '0;
            phase_reg   <= 2'd0;
        end
        else
        begin
            running_reg <= running_next;
            pending_reg <= pending_next;
            phase_reg   <= phase_next;
        end
    end

    always_comb
    begin
        sts.changed = changed;
        sts.line_a  = phase_next[1];
        sts.line_b  = phase_next[1] ^ phase_next[0];
        sts.running = running_next;
    end

endmodule

// File: rtl/quadrature_step_emulator.sv
// Top level: input register, two encoder axes, line level register and output handshake.
//
//   channel  direction  handshake              payload
//   in       sink       in_valid / in_stall    command, step_delta, active
//   out      source     out_valid / out_stall  x_line_a, x_line_b, y_line_a, y_line_b, fire_line
//
// One item per cycle sustained while out is not stalled; out_valid rises once the item has
// passed the input register and the line register. The item sits in the input register,
// then axis and line state update in one pass while the line register loads the result.
// Reset clears the axes and drives all lines high.
// A stall on out holds the result and back-pressures in within the same cycle.
module quadrature_step_emulator #(
    parameter int PENDING_BITS = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [2:0]                            command,
    input  logic signed [qse_pkg::DELTA_BITS-1:0] step_delta,
    input  logic                                  active,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic                                  x_line_a,
    output logic                                  x_line_b,
    output logic                                  y_line_a,
    output logic                                  y_line_b,
    output logic                                  fire_line
);
    import qse_pkg::*;

    logic                         s1_valid_reg;
    qse_cmd_t                     cmd_reg;
    logic signed [DELTA_BITS-1:0] delta_reg;
    logic                         active_reg;

    logic                         out_valid_reg, out_valid_next;
    logic [LINE_CNT-1:0]          line_reg, line_next;

    logic                         go;
    qse_axis_ctl_t                x_ctl, y_ctl;
    qse_axis_sts_t                x_sts, y_sts;

    assign go       = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !go;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            cmd_reg    <= qse_cmd_t'(command);
            delta_reg  <= step_delta;
            active_reg <= active;
        end
    end

    always_comb
    begin
        x_ctl.fire  = go;
        x_ctl.tick  = (cmd_reg == CMD_TICK);
        x_ctl.queue = (cmd_reg == CMD_QUEUE_X);
        x_ctl.stop  = ((cmd_reg == CMD_UP) || (cmd_reg == CMD_DOWN)) && active_reg;
        y_ctl.fire  = go;
        y_ctl.tick  = (cmd_reg == CMD_TICK);
        y_ctl.queue = (cmd_reg == CMD_QUEUE_Y);
        y_ctl.stop  = ((cmd_reg == CMD_LEFT) || (cmd_reg == CMD_RIGHT)) && active_reg;
    end

    qse_axis #(
        .PENDING_BITS(PENDING_BITS)
    ) u_axis_x (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (x_ctl),
        .step_delta(delta_reg),
        .sts       (x_sts)
    );

    qse_axis #(
        .PENDING_BITS(PENDING_BITS)
    ) u_axis_y (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (y_ctl),
        .step_delta(delta_reg),
        .sts       (y_sts)
    );

    always_comb
    begin
        line_next = line_reg;
        case (cmd_reg)
            CMD_TICK:
            begin
                if (x_sts.changed)
                begin
                    line_next[LINE_XA] = x_sts.line_a;
                    line_next[LINE_XB] = x_sts.line_b;
                end
                if (y_sts.changed)
                begin
                    line_next[LINE_YA] = y_sts.line_a;
                    line_next[LINE_YB] = y_sts.line_b;
                end
            end
            CMD_UP:
            begin
                if (!x_sts.running)
                begin
                    line_next[LINE_XA] = !active_reg;
                end
            end
            CMD_DOWN:
            begin
                if (!x_sts.running)
                begin
                    line_next[LINE_XB] = !active_reg;
                end
            end
            CMD_LEFT:
            begin
                if (!y_sts.running)
                begin
                    line_next[LINE_YA] = !active_reg;
                end
            end
            CMD_RIGHT:
            begin
                if (!y_sts.running)
                begin
                    line_next[LINE_YB] = !active_reg;
                end
            end
            CMD_TRIGGER:
            begin
                line_next[LINE_FIRE] = !active_reg;
            end
            default:
            begin
                line_next = line_reg;
            end
        endcase
    end

    assign out_valid_next = go || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            line_reg      <= '1;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (go)
            begin
                line_reg <= line_next;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign x_line_a  = line_reg[LINE_XA];
    assign x_line_b  = line_reg[LINE_XB];
    assign y_line_a  = line_reg[LINE_YA];
    assign y_line_b  = line_reg[LINE_YB];
    assign fire_line = line_reg[LINE_FIRE];

endmodule
